// ===== design/oxygen_sensor_line_parser_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the oxygen sensor line parser modules.
// ---------------------------------------------------------------------------
`ifndef OXYGEN_SENSOR_LINE_PARSER_CORE_ASSERT_SVH
`define OXYGEN_SENSOR_LINE_PARSER_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define OLP_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

// Consequent that must hold in the cycle after the antecedent
`define OLP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== design/olp_pkg.sv =====
// ---------------------------------------------------------------------------
// olp_pkg
// Types and constants of the oxygen sensor line parser.
// ---------------------------------------------------------------------------
package olp_pkg;

  localparam int QDEPTH = 2;
  localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [5:0] POS_MAX = 6'd63;

  // Last line position of each field
  localparam logic [5:0] LAST_PPO2 = 6'd7;
  localparam logic [5:0] LAST_TEMP = 6'd15;
  localparam logic [5:0] LAST_PRES = 6'd22;
  localparam logic [5:0] LAST_PCT  = 6'd31;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_SIGN,
    KIND_EOL
  } kind_t;

  typedef enum logic [1:0] {
    FIELD_PPO2,
    FIELD_TEMP,
    FIELD_PRES,
    FIELD_PCT
  } field_t;

  typedef struct packed {
    kind_t       kind;
    field_t      field;
    logic        is_digit;
    logic [3:0]  digit;
    logic        neg;
    logic [5:0]  pos;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    logic   full;
    entry_t entry;
  } q_rd_t;

endpackage

// ===== design/olp_in_if.sv =====
// ---------------------------------------------------------------------------
// olp_in_if
// Byte channel from the sensor UART.
// ---------------------------------------------------------------------------
interface olp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/olp_out_if.sv =====
// ---------------------------------------------------------------------------
// olp_out_if
// Result channel carrying one parsed sensor line.
// ---------------------------------------------------------------------------
interface olp_out_if;
  logic               valid;
  logic               ready;
  logic        [19:0] oxygen_partial_pressure;
  logic signed [14:0] temperature_scaled;
  logic        [23:0] pressure_scaled;
  logic        [13:0] oxygen_percent_hundredths;
  logic               fields_clean;

  modport source (output valid, output oxygen_partial_pressure, output temperature_scaled,
                  output pressure_scaled, output oxygen_percent_hundredths,
                  output fields_clean, input ready);
  modport sink   (input valid, input oxygen_partial_pressure, input temperature_scaled,
                  input pressure_scaled, input oxygen_percent_hundredths,
                  input fields_clean, output ready);
endinterface

// ===== design/olp_front.sv =====
// ---------------------------------------------------------------------------
// olp_front
// Tracks the line position and turns each byte that matters into a queue
// entry: field digit, sign character or end of line.
// ---------------------------------------------------------------------------
module olp_front
  import olp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  olp_in_if.sink     rx,
  input  logic       full,
  output q_wr_t      wr
);

  logic [5:0] pos;
  logic [5:0] pos_next;
  logic       accept;
  logic       is_cr;
  logic       skip_lf;
  logic       take;
  kind_t      kind;
  field_t     field;

  assign rx.ready = !full;
  assign accept   = rx.valid && rx.ready;
  assign is_cr    = (rx.rx_byte == CHAR_CR);
  assign skip_lf  = (rx.rx_byte == CHAR_LF) && (pos == 6'd0);

  // Map the position to the field it feeds
  always_comb begin
    take  = 1'b1;
    kind  = KIND_DIGIT;
    field = FIELD_PPO2;
    case (pos)
      6'd2, 6'd3, 6'd4, 6'd5, 6'd7: field = FIELD_PPO2;
      6'd11: kind = KIND_SIGN;
      6'd12, 6'd13, 6'd15: field = FIELD_TEMP;
      6'd19, 6'd20, 6'd21, 6'd22: field = FIELD_PRES;
      6'd27, 6'd28, 6'd30, 6'd31: field = FIELD_PCT;
      default: take = 1'b0;
    endcase
  end

  // Build the entry for this byte
  always_comb begin
    wr.entry.kind     = is_cr ? KIND_EOL : kind;
    wr.entry.field    = field;
    wr.entry.is_digit = (rx.rx_byte >= CHAR_ZERO) && (rx.rx_byte <= CHAR_NINE);
    wr.entry.digit    = rx.rx_byte[3:0];
    wr.entry.neg      = (rx.rx_byte == CHAR_MINUS);
    wr.entry.pos      = pos;
    wr.push           = accept && (is_cr || (take && !skip_lf));
  end

  // Advance the position up to POS_MAX, restart it on CR
  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (is_cr) begin
        pos_next = 6'd0;
      end else if (!skip_lf && pos != POS_MAX) begin
        pos_next = pos + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 6'd0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

// ===== design/olp_fifo.sv =====
// ---------------------------------------------------------------------------
// olp_fifo
// Short queue of classified entries between the front and the back.
// ---------------------------------------------------------------------------
`include "oxygen_sensor_line_parser_core_assert.svh"

module olp_fifo
  import olp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t wr,
  input  logic  pop,
  output q_rd_t rd
);

  entry_t            mem [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign rd.valid = (count != '0);
  assign rd.full  = (count == QCNT_W'(QDEPTH));
  assign rd.entry = mem[rd_ptr];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.entry;
    end
  end

  // Move the pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr + QIDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr + QIDX_W'(1);
      end
      count <= count + QCNT_W'(wr.push) - QCNT_W'(pop);
    end
  end

  `OLP_ASSERT(a_no_overflow, clk, rst, !(wr.push && rd.full))
  `OLP_ASSERT(a_no_underflow, clk, rst, !(pop && !rd.valid))
  `OLP_ASSERT_NEXT(a_push_shows, clk, rst, wr.push && !pop, rd.valid)

endmodule

// ===== design/olp_back.sv =====
// ---------------------------------------------------------------------------
// olp_back
// Gathers field digits from the queue and, at end of line, scales the
// fields into the output register.
// ---------------------------------------------------------------------------
`include "oxygen_sensor_line_parser_core_assert.svh"

module olp_back
  import olp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  q_rd_t    rd,
  output logic     pop,
  olp_out_if.source tx
);

  logic [19:0] acc_ppo2;
  logic [13:0] acc_temp;
  logic [23:0] acc_pres;
  logic [13:0] acc_pct;
  logic [3:0]  stopped;
  logic        neg;
  logic        out_valid;

  logic [19:0] acc_ppo2_next;
  logic [13:0] acc_temp_next;
  logic [23:0] acc_pres_next;
  logic [13:0] acc_pct_next;
  logic [3:0]  stopped_next;
  logic        neg_next;

  logic        eol_pop;
  logic        live;
  logic [3:0]  d;
  logic [19:0] fin_ppo2;
  logic [14:0] fin_temp;
  logic [23:0] fin_pres;
  logic [13:0] fin_pct;
  logic [3:0]  dirty;

  // Take an entry unless an end of line waits on a full output register
  assign pop     = rd.valid && (rd.entry.kind != KIND_EOL || !out_valid || tx.ready);
  assign eol_pop = pop && (rd.entry.kind == KIND_EOL);
  assign d       = rd.entry.digit;
  assign live    = !stopped[rd.entry.field];

  // Accumulate digits, stop a field at its first non-digit, latch the sign, clear all at end of line
  always_comb begin
    acc_ppo2_next = acc_ppo2;
    acc_temp_next = acc_temp;
    acc_pres_next = acc_pres;
    acc_pct_next  = acc_pct;
    stopped_next  = stopped;
    neg_next      = neg;
    if (eol_pop) begin
      acc_ppo2_next = '0;
      acc_temp_next = '0;
      acc_pres_next = '0;
      acc_pct_next  = '0;
      stopped_next  = '0;
      neg_next      = 1'b0;
    end else if (pop && rd.entry.kind == KIND_SIGN) begin
      neg_next = rd.entry.neg;
    end else if (pop && rd.entry.kind == KIND_DIGIT && live) begin
      if (!rd.entry.is_digit) begin
        stopped_next[rd.entry.field] = 1'b1;
      end else begin
        case (rd.entry.field)
          FIELD_PPO2: acc_ppo2_next = (acc_ppo2 << 3) + (acc_ppo2 << 1) + 20'(d);
          FIELD_TEMP: acc_temp_next = (acc_temp << 3) + (acc_temp << 1) + 14'(d);
          FIELD_PRES: acc_pres_next = (acc_pres << 3) + (acc_pres << 1) + 24'(d);
          FIELD_PCT:  acc_pct_next  = (acc_pct << 3) + (acc_pct << 1) + 14'(d);
          default:    acc_ppo2_next = acc_ppo2;
        endcase
      end
    end
  end

  // Scale the finished ppO2, temperature and pressure fields; leave short or broken ones unscaled
  always_comb begin
    dirty[0] = stopped[0] || (rd.entry.pos <= LAST_PPO2);
    dirty[1] = stopped[1] || (rd.entry.pos <= LAST_TEMP);
    dirty[2] = stopped[2] || (rd.entry.pos <= LAST_PRES);
    dirty[3] = stopped[3] || (rd.entry.pos <= LAST_PCT);
    fin_ppo2 = dirty[0] ? acc_ppo2 : 20'(acc_ppo2 * 20'd100);
    fin_temp = dirty[1] ? {1'b0, acc_temp} : 15'({1'b0, acc_temp} * 15'd10);
    fin_pres = dirty[2] ? acc_pres : 24'(acc_pres * 24'd1000);
    fin_pct  = acc_pct;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_ppo2  <= '0;
      acc_temp  <= '0;
      acc_pres  <= '0;
      acc_pct   <= '0;
      stopped   <= '0;
      neg       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      acc_ppo2 <= acc_ppo2_next;
      acc_temp <= acc_temp_next;
      acc_pres <= acc_pres_next;
      acc_pct  <= acc_pct_next;
      stopped  <= stopped_next;
      neg      <= neg_next;
      if (eol_pop) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output register at end of line
  always_ff @(posedge clk) begin
    if (eol_pop) begin
      tx.oxygen_partial_pressure   <= fin_ppo2;
      tx.temperature_scaled        <= neg ? $signed(15'(-fin_temp)) : $signed(fin_temp);
      tx.pressure_scaled           <= fin_pres;
      tx.oxygen_percent_hundredths <= fin_pct;
      tx.fields_clean              <= (dirty == 4'b0000);
    end
  end

  assign tx.valid = out_valid;

  `OLP_ASSERT_NEXT(a_eol_loads, clk, rst, eol_pop, out_valid)
  `OLP_ASSERT_NEXT(a_eol_clears, clk, rst, eol_pop,
    stopped == 4'b0000 && !neg && acc_ppo2 == '0 && acc_pres == '0)
  `OLP_ASSERT(a_valid_from_eol, clk, rst, $rose(out_valid) |-> $past(eol_pop))

endmodule

// ===== design/oxygen_sensor_line_parser_core.sv =====
// ---------------------------------------------------------------------------
// oxygen_sensor_line_parser_core
// Parses the sensor's ASCII status line into four scaled values.
// ---------------------------------------------------------------------------
// Use:
//   rx carries one UART byte per beat; tx carries one result beat per line,
//   given when CR arrives: ppO2 times 100, temperature times 10 (signed),
//   pressure times 1000, oxygen percent in hundredths and a clean flag.
//   Bytes other than CR give no result beat.
// Timing:
//   One byte is taken every cycle while the queue is not full. The front
//   classifies a byte by its line position and queues it in a two-entry
//   queue; the back then pops it and updates the digit accumulators. A
//   result beat appears once its CR has passed the queue and the output
//   register is loaded with the scaled fields.
// Stall:
//   While a result beat waits on tx, digit entries still drain; a second CR
//   waits at the queue head, and rx.ready drops only once the queue fills.
// Reset:
//   rst (synchronous) empties the queue, clears the output valid, the line
//   position and all accumulators; no clearing pass follows.
// ---------------------------------------------------------------------------
module oxygen_sensor_line_parser_core
  import olp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  olp_in_if.sink    rx,
  olp_out_if.source tx
);

  q_wr_t wr;
  q_rd_t rd;
  logic  pop;

  olp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .full (rd.full),
    .wr   (wr)
  );

  olp_fifo u_fifo (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .pop (pop),
    .rd  (rd)
  );

  olp_back u_back (
    .clk (clk),
    .rst (rst),
    .rd  (rd),
    .pop (pop),
    .tx  (tx)
  );

endmodule
